@@ hdl/gmig_pkg.sv @@
// Shared types and constants for the grid mesh index generator.
// No dependencies; imported by gmig_step and grid_mesh_index_generator.
package gmig_pkg;

	// Upper bound on cells per side
	localparam int GMIG_MAX_CELLS = 255;

	// Register widths
	localparam int CELLS_W = 8;
	localparam int COL_W   = 9;
	localparam int IDX_W   = 16;
	localparam int CFG_IDX_W = 4;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_PATCH_CELLS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIRE_MODE   = 4'd1;

	// Reset values of the registers
	localparam logic [CELLS_W-1:0] PATCH_CELLS_RST = 8'd16;
	localparam logic               WIRE_MODE_RST   = 1'b0;

	// Strip phases: index on the current row, then on the next row
	localparam logic [1:0] PH_ROW_CUR  = 2'd0;
	localparam logic [1:0] PH_ROW_NEXT = 2'd1;

	// Wireframe phases: horizontal edge (two ends), then vertical edge
	localparam logic [1:0] PH_EDGE_H0 = 2'd0;
	localparam logic [1:0] PH_EDGE_H1 = 2'd1;
	localparam logic [1:0] PH_EDGE_V0 = 2'd2;
	localparam logic [1:0] PH_EDGE_V1 = 2'd3;

	// Position within the mesh
	typedef struct packed {
		logic [CELLS_W-1:0] row;
		logic [COL_W-1:0]   col;
		logic [1:0]         phase;
		logic               degen;
	} gmig_pos_t;

	// Result of one step: next position and the index it emits
	typedef struct packed {
		gmig_pos_t        pos;
		logic [IDX_W-1:0] idx;
		logic             last;
	} gmig_step_t;

endpackage

@@ hdl/grid_mesh_index_generator.sv @@
// Grid mesh index generator: top level with registers, position state and output stage.
// Depends on gmig_pkg and gmig_step.
//
// Each item accepted on the input channel (in_valid/in_ready, field restart)
// yields exactly one item on the output channel (out_valid/out_ready, fields
// vertex_index and mesh_last). With restart high the item gives the first
// index of a new mesh; otherwise the walk continues where it stopped.
// An accepted item is loaded into the single output register and offered in the
// next cycle. Throughput is one item per cycle while the receiver takes them, set by
// that register; in_ready stays high while that register is empty or being emptied.
// When the receiver stalls, the output holds and in_ready falls until the
// item is taken. mesh_last marks the final index; the next item starts over.
// Registers patch_cells (index 0) and wire_mode (index 1) are written on the
// cfg channel, always ready; the user must write them only while the block is idle;
// the block does not enforce it. Reset restores patch_cells to 16, strip mode, the
// start of a mesh and an empty output. The row start is recomputed from the row count
// on every item, so a register change between meshes takes effect on the next item.
module grid_mesh_index_generator import gmig_pkg::*; #(
	parameter int MAX_PATCH_CELLS = GMIG_MAX_CELLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IDX_W-1:0]     vertex_index,
	output logic                 mesh_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CELLS_W-1:0]   cfg_data
);

	logic [CELLS_W-1:0] patch_cells_q;
	logic               wire_mode_q;
	gmig_pos_t          pos_q;
	gmig_step_t         step;
	logic               out_valid_q;
	logic [IDX_W-1:0]   vertex_index_q;
	logic               mesh_last_q;
	logic               in_fire;

	assign cfg_ready    = 1'b1;
	assign in_ready     = !out_valid_q || out_ready;
	assign in_fire      = in_valid && in_ready;
	assign out_valid    = out_valid_q;
	assign vertex_index = vertex_index_q;
	assign mesh_last    = mesh_last_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_cells_q <= PATCH_CELLS_RST;
			wire_mode_q   <= WIRE_MODE_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_PATCH_CELLS) begin
				patch_cells_q <= cfg_data;
			end else if (cfg_index == CFG_WIRE_MODE) begin
				wire_mode_q <= cfg_data[0];
			end
		end
	end

	gmig_step #(
		.MAX_PATCH_CELLS(MAX_PATCH_CELLS)
	) u_step (
		.pos        (pos_q),
		.patch_cells(patch_cells_q),
		.wire_mode  (wire_mode_q),
		.restart    (restart),
		.step       (step)
	);

	// Position state advances on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_fire) begin
			pos_q <= step.pos;
		end
	end

	// Output stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			vertex_index_q <= step.idx;
			mesh_last_q    <= step.last;
		end
	end

	// A mesh end returns the walk to its start
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && step.last |=> pos_q == '0)
		else $error("position not cleared after mesh end");

	// An output item appears only after an accepted input item
	a_out_from_in: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("output item without input item");

	// A pending degenerate always sits at the start of a row
	a_degen_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!wire_mode_q && pos_q.degen |-> pos_q.col == '0 && pos_q.phase == PH_ROW_CUR)
		else $error("degenerate pending mid-row");

	// Stored row never reaches the largest cell count
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> pos_q.row != '1)
		else $error("row count out of range");

endmodule

@@ hdl/gmig_step.sv @@
// Next-position and index logic for one advance of the grid mesh walk.
// Depends on gmig_pkg for the position struct and phase codes.
module gmig_step import gmig_pkg::*; #(
	parameter int MAX_PATCH_CELLS = GMIG_MAX_CELLS
) (
	input  gmig_pos_t          pos,
	input  logic [CELLS_W-1:0] patch_cells,
	input  logic               wire_mode,
	input  logic               restart,
	output gmig_step_t         step
);

	localparam logic [CELLS_W-1:0] MaxCells = CELLS_W'(MAX_PATCH_CELLS);

	logic [CELLS_W-1:0] p;
	logic [COL_W-1:0]   p9;
	logic [COL_W-1:0]   v;
	logic [COL_W-1:0]   row9;
	logic [COL_W-1:0]   col_inc;
	logic [COL_W-1:0]   x;
	logic [16:0]        prod;
	logic [IDX_W-1:0]   rb;
	logic [IDX_W-1:0]   base;
	logic               valid;
	gmig_pos_t          cur;

	always_comb begin
		// Clamp cell count, vertices per side is one more
		p = (patch_cells == '0) ? CELLS_W'(1) : patch_cells;
		if (p > MaxCells) begin
			p = MaxCells;
		end
		p9 = {1'b0, p};
		v  = p9 + COL_W'(1);

		// Restart, then drop any position that does not fit the registers
		cur = restart ? '0 : pos;
		if (wire_mode) begin
			cur.degen = 1'b0;
			valid = ({1'b0, cur.row} < p9) && (cur.col < p9);
		end else begin
			valid = ({1'b0, cur.row} < p9) && (cur.col < v) && (cur.phase <= PH_ROW_NEXT) &&
				!(cur.degen && ((({1'b0, cur.row} + COL_W'(1)) >= p9) ||
				(cur.col != '0) || (cur.phase != PH_ROW_CUR)));
		end
		if (!valid) begin
			cur = '0;
		end

		// Row start index; fits 16 bits since row < cells
		prod    = 17'(cur.row) * 17'(v);
		rb      = prod[IDX_W-1:0];
		row9    = {1'b0, cur.row} + COL_W'(1);
		col_inc = cur.col + COL_W'(1);
		base    = rb + IDX_W'(cur.col);
		x       = cur.row[0] ? (v - COL_W'(1) - cur.col) : cur.col;

		step.pos  = cur;
		step.idx  = '0;
		step.last = 1'b0;

		if (wire_mode) begin
			// Four indices per cell
			unique case (cur.phase)
				PH_EDGE_H0: step.idx = base;
				PH_EDGE_H1: step.idx = base + IDX_W'(1);
				PH_EDGE_V0: step.idx = base;
				PH_EDGE_V1: step.idx = base + IDX_W'(v);
				default:    step.idx = base;
			endcase
			if (cur.phase != PH_EDGE_V1) begin
				step.pos.phase = cur.phase + 2'd1;
			end else begin
				step.pos.phase = PH_EDGE_H0;
				step.pos.col   = col_inc;
				if (col_inc == p9) begin
					step.pos.col = '0;
					step.pos.row = row9[CELLS_W-1:0];
					if (row9 == p9) begin
						step.last = 1'b1;
						step.pos  = '0;
					end
				end
			end
		end else if (cur.degen) begin
			// Repeat the end vertex of the row just finished
			step.idx       = rb + (cur.row[0] ? '0 : IDX_W'(v - COL_W'(1)));
			step.pos.degen = 1'b0;
			step.pos.row   = row9[CELLS_W-1:0];
			step.pos.col   = '0;
			step.pos.phase = PH_ROW_CUR;
		end else if (cur.phase == PH_ROW_CUR) begin
			step.idx       = rb + IDX_W'(x);
			step.pos.phase = PH_ROW_NEXT;
		end else begin
			step.idx       = rb + IDX_W'(v) + IDX_W'(x);
			step.pos.phase = PH_ROW_CUR;
			step.pos.col   = col_inc;
			if (col_inc == v) begin
				step.pos.col = '0;
				if (row9 == p9) begin
					step.last = 1'b1;
					step.pos  = '0;
				end else begin
					step.pos.degen = 1'b1;
				end
			end
		end
	end

endmodule

@@ tb/sv/grid_mesh_index_check.sv @@
// Watches the channels of grid_mesh_index_generator, predicts every vertex index and compares.
// Depends on gmig_pkg for widths, register indexes, reset values and phase codes.
module grid_mesh_index_check import gmig_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 restart,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [IDX_W-1:0]     vertex_index,
	input  logic                 mesh_last,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CELLS_W-1:0]   cfg_data,
	output int                   mismatch_count,
	output int                   pending
);

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             last;
	} mesh_index_t;

	// Predicted indices, oldest first
	mesh_index_t index_fifo[$];

	// Shadow registers
	logic [CELLS_W-1:0] cells_q;
	logic               wire_q;

	// Walk position
	int unsigned row_q;
	int unsigned col_q;
	int unsigned phase_q;
	bit          degen_q;

	function automatic void clear_walk();
		row_q   = 0;
		col_q   = 0;
		phase_q = 0;
		degen_q = 0;
	endfunction

	// Advance the walk by one index and return what it emits
	function automatic mesh_index_t walk_mesh(input logic rst);
		mesh_index_t res;
		int unsigned p;
		int unsigned v;
		int unsigned row_base;
		int unsigned idx;
		int unsigned x;
		bit          ok;
		bit          odd;
		p = cells_q;
		if (p == 0) p = 1;
		if (p > GMIG_MAX_CELLS) p = GMIG_MAX_CELLS;
		v = p + 1;
		idx = 0;
		res.last = 1'b0;
		if (rst) clear_walk();

		// a position that does not fit the current registers starts a new mesh
		if (wire_q) begin
			degen_q = 0;
			ok = row_q < p && col_q < p && phase_q <= PH_EDGE_V1;
		end else begin
			ok = row_q < p && col_q < v && phase_q <= PH_ROW_NEXT &&
				!(degen_q && (row_q + 1 >= p || col_q != 0 || phase_q != PH_ROW_CUR));
		end
		if (!ok) clear_walk();
		row_base = row_q * v;

		if (wire_q) begin
			// horizontal edge, then vertical edge of cell (row, col)
			case (phase_q)
				PH_EDGE_H0: idx = row_base + col_q;
				PH_EDGE_H1: idx = row_base + col_q + 1;
				PH_EDGE_V0: idx = row_base + col_q;
				default:    idx = row_base + col_q + v;
			endcase
			if (phase_q < PH_EDGE_V1) begin
				phase_q++;
			end else begin
				phase_q = PH_EDGE_H0;
				col_q++;
				if (col_q == p) begin
					col_q = 0;
					row_q++;
					if (row_q == p) begin
						res.last = 1'b1;
						clear_walk();
					end
				end
			end
		end else begin
			odd = row_q[0];
			if (degen_q) begin
				// repeat the end vertex of the row just finished
				idx = row_base + (odd ? 0 : v - 1);
				degen_q = 0;
				row_q++;
				col_q = 0;
				phase_q = PH_ROW_CUR;
			end else begin
				x = odd ? (v - 1 - col_q) : col_q;
				if (phase_q == PH_ROW_CUR) begin
					idx = row_base + x;
					phase_q = PH_ROW_NEXT;
				end else begin
					idx = row_base + v + x;
					phase_q = PH_ROW_CUR;
					col_q++;
					if (col_q == v) begin
						col_q = 0;
						if (row_q + 1 == p) begin
							res.last = 1'b1;
							clear_walk();
						end else begin
							degen_q = 1;
						end
					end
				end
			end
		end
		res.idx = idx[IDX_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		mesh_index_t want;
		if (!arst_n) begin
			cells_q = PATCH_CELLS_RST;
			wire_q  = WIRE_MODE_RST;
			clear_walk();
			index_fifo.delete();
			mismatch_count = 0;
			pending = 0;
		end else begin
			// result side first: anything taken now was predicted earlier
			if (out_valid && out_ready) begin
				if (index_fifo.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual index %0d last %0b",
						$time, vertex_index, mesh_last);
					mismatch_count++;
				end else begin
					want = index_fifo.pop_front();
					if (vertex_index !== want.idx) begin
						$display("%0t: vertex_index expected %0d actual %0d",
							$time, want.idx, vertex_index);
						mismatch_count++;
					end
					if (mesh_last !== want.last) begin
						$display("%0t: mesh_last expected %0b actual %0b",
							$time, want.last, mesh_last);
						mismatch_count++;
					end
				end
			end

			// register writes; unknown indexes are ignored
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PATCH_CELLS: cells_q = cfg_data;
					CFG_WIRE_MODE:   wire_q  = cfg_data[0];
					default: ;
				endcase
			end

			if (in_valid && in_ready)
				index_fifo.push_back(walk_mesh(restart));

			pending = index_fifo.size();
		end
	end

endmodule

@@ tb/sv/grid_mesh_index_generator_test.sv @@
// Top of the grid_mesh_index_generator testbench: clock, reset, stimulus and verdict.
// Depends on gmig_pkg, grid_mesh_index_generator and grid_mesh_index_check.
module grid_mesh_index_generator_test;
	import gmig_pkg::*;

	localparam int ITEM_TARGET = 1500;
	localparam int CALM_START  = 1300;
	localparam int STALL_LIMIT = 5000;

	// no register lives at this index
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'hF;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 restart;
	logic                 out_valid;
	logic                 out_ready;
	logic [IDX_W-1:0]     vertex_index;
	logic                 mesh_last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CELLS_W-1:0]   cfg_data;

	int mismatch_count;
	int pending;
	int sent;
	int quiet_cycles;
	bit jitter_on;

	grid_mesh_index_generator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vertex_index (vertex_index),
		.mesh_last    (mesh_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	grid_mesh_index_check u_mesh_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.restart        (restart),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.vertex_index   (vertex_index),
		.mesh_last      (mesh_last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	always #5 clk = ~clk;

	// One item; holds valid and restart until taken
	task automatic send_item(input logic rst);
		if (jitter_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stop sending and wait until every predicted index has come out
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CELLS_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_mesh(input logic [CELLS_W-1:0] cells, input logic wire_sel);
		if ($urandom_range(0, 9) == 0)
			write_reg(CFG_UNUSED, CELLS_W'($urandom));
		write_reg(CFG_PATCH_CELLS, cells);
		write_reg(CFG_WIRE_MODE, {7'($urandom), wire_sel});
		cfg_valid <= 1'b0;
	endtask

	// count items; restart with odds 1 in restart_odds, or only on the first when zero
	task automatic send_run(input int count, input int restart_odds, input logic first_rst);
		logic rst;
		for (int k = 0; k < count; k++) begin
			if (restart_odds == 0)
				rst = (k == 0) ? first_rst : 1'b0;
			else
				rst = ($urandom_range(0, restart_odds - 1) == 0);
			send_item(rst);
			sent++;
			if (sent >= CALM_START) jitter_on = 0;
			// now and then let the output drain completely
			if (restart_odds != 0 && $urandom_range(0, 149) == 0) settle();
		end
	endtask

	// Receiver: random stall bursts while jitter is on
	initial begin
		@(posedge arst_n);
		forever begin
			if (jitter_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("Some tests failed");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [CELLS_W-1:0] cells;
		int                 pick;
		int                 odds;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		restart = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PATCH_CELLS;
		cfg_data = '0;
		sent = 0;
		quiet_cycles = 0;
		jitter_on = 1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset registers: 16 cells, strip; restart in the middle of a row
		send_run(2, 0, 1'b0);
		send_run(2, 0, 1'b1);
		settle();

		// one cell strip: a whole mesh and the start of the next
		set_mesh(8'd1, 1'b0);
		send_run(5, 0, 1'b1);
		settle();

		// zero cells behaves as one, wireframe
		set_mesh(8'd0, 1'b1);
		send_run(5, 0, 1'b1);
		settle();

		// largest patch, strip, stopped on a next-row index
		set_mesh(8'hFF, 1'b0);
		send_run(3, 0, 1'b1);
		settle();

		// switch to wireframe mid-mesh: the walk carries on
		write_reg(CFG_WIRE_MODE, 8'h01);
		cfg_valid <= 1'b0;
		send_run(2, 0, 1'b0);
		settle();

		// back to strip with a wireframe phase left over: starts over
		write_reg(CFG_UNUSED, 8'hFF);
		write_reg(CFG_PATCH_CELLS, 8'd2);
		write_reg(CFG_WIRE_MODE, 8'hFE);
		cfg_valid <= 1'b0;
		send_run(4, 0, 1'b0);
		settle();

		// random settings; meshes mostly small so many complete
		while (sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				cells = 8'd0;
			else if (pick == 1)
				cells = 8'hFF;
			else if (pick < 5)
				cells = CELLS_W'($urandom_range(7, 40));
			else
				cells = CELLS_W'($urandom_range(1, 6));
			odds = ($urandom_range(0, 5) == 0) ? 2 : 32;
			if (sent < CALM_START) jitter_on = ($urandom_range(0, 2) != 0);
			set_mesh(cells, 1'($urandom_range(0, 1)));
			send_run($urandom_range(20, 120), odds, 1'b0);
			settle();
		end

		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
